@@ src/c_token_scanner_assert.svh @@
// assertion macros for the token scanner
`ifndef C_TOKEN_SCANNER_ASSERT_SVH
`define C_TOKEN_SCANNER_ASSERT_SVH
`define CTS_ASSERT_IMPL(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);
`define CTS_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);
`endif

@@ src/cts_pkg.sv @@
`default_nettype none
package cts_pkg;
	localparam int PosBits  = 32;
	localparam int LineBits = 32;
	localparam int MaxLen   = 1022;

	localparam logic [3:0] K_EOF = 4'd0, K_MINUS = 4'd1, K_BOPEN = 4'd2, K_BCLOSE = 4'd3,
		K_COMMA = 4'd4, K_ASSIGN = 4'd5, K_NUMBER = 4'd6, K_NAME = 4'd7, K_ERROR = 4'd8;
	localparam logic [2:0] E_NONE = 3'd0, E_OPEN = 3'd1, E_STRAY = 3'd2, E_OVERFLOW = 3'd3,
		E_SEP = 3'd4, E_BAD = 3'd5, E_UNSUP = 3'd6, E_LONG = 3'd7;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] line;
		logic [31:0] offset;
		logic [9:0]  length;
		logic [63:0] value;
		logic [2:0]  ltype;
		logic [2:0]  err;
		logic        last;
	} token_t;

	// classified request handed from front to back
	typedef struct packed {
		logic       eos;
		logic [7:0] b;
		logic       is_digit;
		logic       is_first;
		logic       is_trailer;
		logic [4:0] hexv;
	} req_t;
endpackage
`default_nettype wire

@@ src/cts_front.sv @@
`default_nettype none
module cts_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         kind,
	input  wire logic [7:0]   source_byte,
	input  wire logic         push,
	output logic              full,
	output cts_pkg::req_t     req,
	output logic              req_valid,
	input  wire logic         req_take
);
	import cts_pkg::*;
	// two-entry queue of classified requests
	req_t   mem_q [2];
	logic   wp_q, rp_q;
	logic [1:0] cnt_q;
	req_t   c;
	logic   wr, rd;

	always_comb begin
		c = '0;
		c.eos = kind;
		c.b = source_byte;
		c.is_digit = source_byte >= 8'h30 && source_byte <= 8'h39;
		c.is_first = (source_byte >= 8'h61 && source_byte <= 8'h7a) ||
			(source_byte >= 8'h41 && source_byte <= 8'h5a) || source_byte == 8'h5f;
		c.is_trailer = c.is_first || c.is_digit;
		if (c.is_digit) c.hexv = {1'b0, source_byte[3:0]};
		else if ((source_byte >= 8'h61 && source_byte <= 8'h66) ||
			(source_byte >= 8'h41 && source_byte <= 8'h46))
			c.hexv = {1'b0, source_byte[3:0] + 4'd9};
		else c.hexv = 5'h1f;
	end

	assign full = cnt_q == 2'd2;
	assign wr = push && !full;
	assign req_valid = cnt_q != 2'd0;
	assign rd = req_valid && req_take;
	assign req = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= c;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

@@ src/cts_back.sv @@
`default_nettype none
`include "c_token_scanner_assert.svh"
module cts_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  cts_pkg::req_t     req,
	input  wire logic         req_valid,
	output logic              req_take,
	output cts_pkg::token_t   tok0,
	output cts_pkg::token_t   tok1,
	output logic [1:0]        ntok,
	input  wire logic         out_room
);
	import cts_pkg::*;
	localparam logic [3:0] M_IDLE = 4'd0, M_SLASH = 4'd1, M_BOPEN = 4'd2, M_BLOCK = 4'd3,
		M_BSTAR = 4'd4, M_LINE = 4'd5, M_STAR = 4'd6, M_NAME = 4'd7, M_ZERO = 4'd8,
		M_RADIX = 4'd9, M_DEC = 4'd10, M_SUFFIX = 4'd11;
	localparam logic [63:0] Lim = 64'd1844674407370955161;

	logic [3:0]          mode_q, mode_d;
	logic [LineBits-1:0] line_q, line_d;
	logic [PosBits-1:0]  pos_q, pos_d;
	logic [PosBits-1:0]  start_q, start_d;
	logic [9:0]          len_q, len_d;
	logic [63:0]         acc_q, acc_d;
	logic [2:0]          rs_q, rs_d;
	logic                sep_q, sep_d, uns_q, uns_d;
	logic                err_q, err_d;
	token_t              t [2];
	logic [1:0]          n;
	logic                go;
	logic [7:0]          b;
	logic [4:0]          dv;
	logic                dok;
	logic [2:0]          s;
	logic                again;
	logic                dec;
	logic [63:0]         mul10;

	assign req_take = out_room;
	assign go = req_valid && out_room;
	assign b = req.b;
	assign mul10 = (acc_q << 3) + (acc_q << 1);

	function automatic logic [2:0] lclass(input logic [63:0] v, input logic u, input logic d);
		if (v[63:32] == 32'd0) begin
			if (u) return 3'd1;
			if (v[31]) return d ? 3'd2 : 3'd1;
			return 3'd0;
		end
		if (u) return 3'd3;
		if (v[63]) return d ? 3'd4 : 3'd3;
		return 3'd2;
	endfunction

	always_comb begin
		mode_d = mode_q; line_d = line_q; pos_d = pos_q; start_d = start_q; len_d = len_q;
		acc_d = acc_q; rs_d = rs_q; sep_d = sep_q; uns_d = uns_q; err_d = err_q;
		t[0] = '0; t[1] = '0; n = 2'd0; again = 1'b0;
		dec = mode_q == M_DEC;
		s = (rs_q == 3'd0) ? 3'd3 : rs_q;
		dv = dec ? (req.is_digit ? {1'b0, b[3:0]} : 5'h1f) : req.hexv;
		dok = dv != 5'h1f && (dec || dv < (5'd1 << s));
		if (req.eos) begin
			if (!err_q) begin
				unique case (mode_q)
					M_SLASH: begin
						t[0] = '{K_ERROR, line_q, start_q, 10'd1, 64'd0, 3'd0, E_BAD, 1'b0};
						n = 2'd1; err_d = 1'b1;
					end
					M_BOPEN, M_BLOCK, M_BSTAR: begin
						t[0] = '{K_ERROR, line_q, start_q, 10'd2, 64'd0, 3'd0, E_OPEN, 1'b0};
						n = 2'd1; err_d = 1'b1;
					end
					M_STAR: begin
						t[0] = '{K_ERROR, line_q, start_q, 10'd1, 64'd0, 3'd0, E_UNSUP, 1'b0};
						n = 2'd1; err_d = 1'b1;
					end
					M_NAME: begin
						t[0] = '{K_NAME, line_q, start_q, len_q, 64'd0, 3'd0, E_NONE, 1'b0};
						n = 2'd1;
					end
					M_RADIX, M_DEC, M_ZERO, M_SUFFIX: begin
						if (sep_q && (mode_q == M_RADIX || mode_q == M_DEC)) begin
							t[0] = '{K_ERROR, line_q, start_q, len_q, 64'd0, 3'd0, E_SEP, 1'b0};
							err_d = 1'b1;
						end else
							t[0] = '{K_NUMBER, line_q, start_q, len_q, acc_q,
								lclass(acc_q, uns_q, rs_q == 3'd0), E_NONE, 1'b0};
						n = 2'd1;
					end
					default: ;
				endcase
				if (!err_d) begin
					t[n[0]] = '{K_EOF, line_q, pos_q, 10'd0, 64'd0, 3'd0, E_NONE, 1'b0};
					n = n + 2'd1;
				end
			end
			mode_d = M_IDLE; line_d = 1; pos_d = '0; start_d = '0; len_d = '0;
			acc_d = '0; rs_d = '0; sep_d = 1'b0; uns_d = 1'b0; err_d = 1'b0;
		end else begin
			pos_d = pos_q + 1'b1;
			if (!err_q) begin
				unique case (mode_q)
					M_SLASH: begin
						if (b == "*") mode_d = M_BOPEN;
						else if (b == "/") mode_d = M_LINE;
						else begin
							t[0] = '{K_ERROR, line_q, start_q, 10'd1, 64'd0, 3'd0, E_BAD, 1'b0};
							n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
						end
					end
					M_BOPEN, M_BLOCK, M_BSTAR: begin
						if (b == 8'h0a) begin line_d = line_q + 1'b1; mode_d = M_BLOCK; end
						else if (b == "*") mode_d = M_BSTAR;
						else if (b == "/" && mode_q == M_BSTAR) mode_d = M_IDLE;
						else mode_d = M_BLOCK;
					end
					M_LINE: if (b == 8'h0a) begin line_d = line_q + 1'b1; mode_d = M_IDLE; end
					M_STAR: begin
						if (b == "/")
							t[0] = '{K_ERROR, line_q, start_q, 10'd2, 64'd0, 3'd0, E_STRAY, 1'b0};
						else
							t[0] = '{K_ERROR, line_q, start_q, 10'd1, 64'd0, 3'd0, E_UNSUP, 1'b0};
						n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
					end
					M_NAME: begin
						if (req.is_trailer) begin
							if (len_q >= 10'(MaxLen)) begin
								t[0] = '{K_ERROR, line_q, start_q, len_q, 64'd0, 3'd0, E_LONG, 1'b0};
								n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
							end else len_d = len_q + 10'd1;
						end else begin
							t[0] = '{K_NAME, line_q, start_q, len_q, 64'd0, 3'd0, E_NONE, 1'b0};
							n = 2'd1; mode_d = M_IDLE; again = 1'b1;
						end
					end
					M_SUFFIX: begin
						if (b == "." || req.is_trailer) begin
							t[0] = '{K_ERROR, line_q, start_q, len_q, 64'd0, 3'd0, E_UNSUP, 1'b0};
							err_d = 1'b1;
						end else begin
							t[0] = '{K_NUMBER, line_q, start_q, len_q, acc_q,
								lclass(acc_q, uns_q, rs_q == 3'd0), E_NONE, 1'b0};
							again = 1'b1;
						end
						n = 2'd1; mode_d = M_IDLE;
					end
					M_ZERO, M_RADIX, M_DEC: begin
						if (mode_q == M_ZERO && (b == "." || (b | 8'h20) == "e")) begin
							t[0] = '{K_ERROR, line_q, start_q, len_q, 64'd0, 3'd0, E_UNSUP, 1'b0};
							n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
						end else if (mode_q == M_ZERO &&
							((b | 8'h20) == "x" || (b | 8'h20) == "b")) begin
							if (len_q >= 10'(MaxLen)) begin
								t[0] = '{K_ERROR, line_q, start_q, len_q, 64'd0, 3'd0, E_LONG, 1'b0};
								n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
							end else begin
								len_d = len_q + 10'd1;
								rs_d = ((b | 8'h20) == "x") ? 3'd4 : 3'd1;
								mode_d = M_RADIX;
							end
						end else begin
							if (mode_q == M_ZERO) begin
								mode_d = M_RADIX; s = 3'd3; rs_d = 3'd3;
								dok = dv != 5'h1f && dv < 5'd8;
							end
							if ((b == 8'h27 && !sep_q) || dok) begin
								if (len_q >= 10'(MaxLen)) begin
									t[0] = '{K_ERROR, line_q, start_q, len_q, 64'd0, 3'd0,
										E_LONG, 1'b0};
									n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
								end else begin
									len_d = len_q + 10'd1;
									if (b == 8'h27 && !sep_q) sep_d = 1'b1;
									else begin
										sep_d = 1'b0;
										if (dec) begin
											if (acc_q > Lim || (acc_q == Lim && dv > 5'd5)) begin
												t[0] = '{K_ERROR, line_q, start_q, len_d, 64'd0,
													3'd0, E_OVERFLOW, 1'b0};
												n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
											end else acc_d = mul10 + 64'(dv);
										end else begin
											if ((acc_q >> (7'd64 - 7'(s))) != 64'd0) begin
												t[0] = '{K_ERROR, line_q, start_q, len_d, 64'd0,
													3'd0, E_OVERFLOW, 1'b0};
												n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
											end else acc_d = (acc_q << s) | 64'(dv);
										end
									end
								end
							end else if (sep_q) begin
								t[0] = '{K_ERROR, line_q, start_q, len_q, 64'd0, 3'd0, E_SEP, 1'b0};
								n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
							end else if ((b | 8'h20) == "u") begin
								if (len_q >= 10'(MaxLen)) begin
									t[0] = '{K_ERROR, line_q, start_q, len_q, 64'd0, 3'd0,
										E_LONG, 1'b0};
									n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
								end else begin
									len_d = len_q + 10'd1; uns_d = 1'b1; mode_d = M_SUFFIX;
								end
							end else if (b == "." || req.is_trailer) begin
								t[0] = '{K_ERROR, line_q, start_q, len_q, 64'd0, 3'd0, E_UNSUP, 1'b0};
								n = 2'd1; err_d = 1'b1; mode_d = M_IDLE;
							end else begin
								t[0] = '{K_NUMBER, line_q, start_q, len_q, acc_q,
									lclass(acc_q, uns_q, rs_d == 3'd0), E_NONE, 1'b0};
								n = 2'd1; mode_d = M_IDLE; again = 1'b1;
							end
						end
					end
					default: again = 1'b1;
				endcase
				if (again) begin
					case (b)
						8'h0a: line_d = line_q + 1'b1;
						8'h20, 8'h09, 8'h0d: ;
						"/", "*", "0": begin
							mode_d = (b == "/") ? M_SLASH : (b == "*") ? M_STAR : M_ZERO;
							start_d = pos_q; len_d = 10'd1; acc_d = '0;
							rs_d = (b == "0") ? 3'd3 : 3'd0; sep_d = 1'b0; uns_d = 1'b0;
						end
						"-", "{", "}", ",", "=": begin
							t[n[0]] = '{(b == "-") ? K_MINUS : (b == "{") ? K_BOPEN :
								(b == "}") ? K_BCLOSE : (b == ",") ? K_COMMA : K_ASSIGN,
								line_q, pos_q, 10'd1, 64'd0, 3'd0, E_NONE, 1'b0};
							n = n + 2'd1;
						end
						default: begin
							if (req.is_trailer) begin
								mode_d = req.is_digit ? M_DEC : M_NAME;
								start_d = pos_q; len_d = 10'd1;
								acc_d = req.is_digit ? 64'(b[3:0]) : 64'd0;
								rs_d = '0; sep_d = 1'b0; uns_d = 1'b0;
							end else begin
								t[n[0]] = '{K_ERROR, line_q, pos_q, 10'd1, 64'd0, 3'd0,
									E_BAD, 1'b0};
								n = n + 2'd1; err_d = 1'b1; mode_d = M_IDLE;
							end
						end
					endcase
				end
			end
		end
		if (n == 2'd1) t[0].last = 1'b1;
		if (n == 2'd2) t[1].last = 1'b1;
	end

	assign tok0 = t[0];
	assign tok1 = t[1];
	assign ntok = go ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; line_q <= 1; pos_q <= '0; start_q <= '0; len_q <= '0;
			acc_q <= '0; rs_q <= '0; sep_q <= 1'b0; uns_q <= 1'b0; err_q <= 1'b0;
		end else if (go) begin
			mode_q <= mode_d; line_q <= line_d; pos_q <= pos_d; start_q <= start_d;
			len_q <= len_d; acc_q <= acc_d; rs_q <= rs_d; sep_q <= sep_d; uns_q <= uns_d;
			err_q <= err_d;
		end
	end

	`CTS_ASSERT_IMPL(a_err_silent, go && err_q && !req.eos, ntok == 2'd0, "output after error")
	`CTS_ASSERT_NEXT(a_eos_reset, go && req.eos, mode_q == M_IDLE && !err_q, "no reset at end")
	`CTS_ASSERT_IMPL(a_len_cap, 1'b1, len_q <= 10'(MaxLen), "length beyond limit")
endmodule
`default_nettype wire

@@ src/c_token_scanner.sv @@
// c_token_scanner: streaming lexer for C-style source, one byte per request.
// Input queue side: push with kind/source_byte while full is low. kind=1
// marks end of source; it completes any pending token, emits eof (unless an
// error was raised) and returns the scanner to its reset state.
// Output queue side: while empty is low the oldest token is on the ports;
// pop takes it. One request yields up to two tokens; last_of_run marks the
// final token of a request.
// Throughput: one request per cycle while the output queue has room; the
// back end's scan step is combinational (a times-ten add or a shift-or on
// the 64-bit accumulator), between the registered input and output queues.
// The output queue holds four tokens; the back end waits while fewer than
// two places are free, and the input queue (two entries) then fills and
// raises full. After reset both queues are empty, line is 1, position 0.
`default_nettype none
`include "c_token_scanner_assert.svh"
module c_token_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        kind,
	input  wire logic [7:0]  source_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       token_kind,
	output logic [31:0]      token_line,
	output logic [31:0]      token_offset,
	output logic [9:0]       token_length,
	output logic [63:0]      literal_value,
	output logic [2:0]       literal_type,
	output logic [2:0]       error_code,
	output logic             last_of_run
);
	import cts_pkg::*;
	req_t   req;
	logic   req_valid, req_take;
	token_t tok0, tok1, head;
	logic [1:0] ntok;
	token_t oq_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic   rd;

	cts_front u_front (.clk, .arst_n, .kind, .source_byte, .push, .full,
		.req, .req_valid, .req_take);
	cts_back u_back (.clk, .arst_n, .req, .req_valid, .req_take, .tok0, .tok1, .ntok,
		.out_room(cnt_q <= 3'd2));

	assign empty = cnt_q == 3'd0;
	assign rd = pop && !empty;
	assign head = oq_q[rp_q];
	assign token_kind = head.kind;
	assign token_line = head.line;
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign literal_value = head.value;
	assign literal_type = head.ltype;
	assign error_code = head.err;
	assign last_of_run = head.last;

	always_ff @(posedge clk) begin
		if (ntok != 2'd0) oq_q[wp_q] <= tok0;
		if (ntok == 2'd2) oq_q[wp_q + 2'd1] <= tok1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + ntok;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, ntok} - {2'b0, rd};
		end
	end

	`CTS_ASSERT_IMPL(a_oq_bound, 1'b1, cnt_q <= 3'd4, "output queue overrun")
	`CTS_ASSERT_NEXT(a_oq_take, rd && ntok == 2'd0, cnt_q == $past(cnt_q) - 3'd1, "count slip")
	`CTS_ASSERT_IMPL(a_two_room, ntok == 2'd2, cnt_q <= 3'd2, "no room for pair")
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
module tb_top;
	import cts_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SLASH, S_BOPEN, S_BLOCK, S_BSTAR, S_LINE, S_STAR, S_NAME,
		S_ZERO, S_RADIX, S_DEC, S_SUFFIX
	} scan_e;

	typedef struct packed {
		logic       kind;
		logic [7:0] b;
	} req_s;

	logic clk, arst_n;
	logic push, full, kind, empty, pop;
	logic [7:0] source_byte;
	logic [3:0] token_kind;
	logic [31:0] token_line, token_offset;
	logic [9:0] token_length;
	logic [63:0] literal_value;
	logic [2:0] literal_type, error_code;
	logic last_of_run;

	c_token_scanner DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.source_byte(source_byte), .empty(empty), .pop(pop), .token_kind(token_kind),
		.token_line(token_line), .token_offset(token_offset), .token_length(token_length),
		.literal_value(literal_value), .literal_type(literal_type),
		.error_code(error_code), .last_of_run(last_of_run)
	);

	req_s pending_reqs[$];
	token_t expected_tokens[$];
	int errors = 0;
	bit stim_done = 0;
	bit hold_long = 0;

	// scanner shadow state
	scan_e sm;
	logic [31:0] ln, bpos, tstart;
	logic [9:0] tbytes;
	logic [63:0] acc;
	logic [2:0] rshift;
	bit fsep, funs, latched;
	token_t outq[$];

	function automatic bit is_first_b(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic bit is_trail_b(logic [7:0] b);
		return is_first_b(b) || (b >= "0" && b <= "9");
	endfunction

	function automatic int hexval(logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "a" && b <= "f") return b - "a" + 10;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		return 255;
	endfunction

	task automatic emit(logic [3:0] k, logic [31:0] off, logic [9:0] len, logic [63:0] v,
			logic [2:0] ty, logic [2:0] e);
		token_t t;
		t.kind = k; t.line = ln; t.offset = off; t.length = len;
		t.value = v; t.ltype = ty; t.err = e; t.last = 0;
		outq.push_back(t);
	endtask

	task automatic raise(logic [2:0] code, logic [31:0] off, logic [9:0] len);
		latched = 1;
		sm = S_IDLE;
		emit(K_ERROR, off, len, 0, 0, code);
	endtask

	function automatic logic [2:0] lit_class();
		bit dec;
		dec = (rshift == 0);
		if (acc <= 64'hFFFF_FFFF) begin
			if (funs) return 1;
			if (acc >= 64'h8000_0000) return dec ? 2 : 1;
			return 0;
		end
		if (funs) return 3;
		if (acc[63]) return dec ? 4 : 3;
		return 2;
	endfunction

	task automatic emit_num();
		sm = S_IDLE;
		emit(K_NUMBER, tstart, tbytes, acc, lit_class(), E_NONE);
	endtask

	task automatic grow(output bit ok);
		if (tbytes >= MaxLen) begin
			raise(E_LONG, tstart, tbytes);
			ok = 0;
		end else begin
			tbytes++;
			ok = 1;
		end
	endtask

	task automatic start_tok(scan_e m, logic [31:0] p);
		sm = m; tstart = p; tbytes = 1; acc = 0; rshift = 0; fsep = 0; funs = 0;
	endtask

	task automatic idle_scan(logic [7:0] b, logic [31:0] p);
		case (b)
			8'h0a: ln++;
			" ", 8'h09, 8'h0d: ;
			"/": start_tok(S_SLASH, p);
			"*": start_tok(S_STAR, p);
			"-": emit(K_MINUS, p, 1, 0, 0, E_NONE);
			"{": emit(K_BOPEN, p, 1, 0, 0, E_NONE);
			"}": emit(K_BCLOSE, p, 1, 0, 0, E_NONE);
			",": emit(K_COMMA, p, 1, 0, 0, E_NONE);
			"=": emit(K_ASSIGN, p, 1, 0, 0, E_NONE);
			"0": begin
				start_tok(S_ZERO, p);
				rshift = 3;
			end
			default: begin
				if (b >= "1" && b <= "9") begin
					start_tok(S_DEC, p);
					acc = b - "0";
				end else if (is_first_b(b)) begin
					start_tok(S_NAME, p);
				end else begin
					raise(E_BAD, p, 1);
				end
			end
		endcase
	endtask

	task automatic digit_scan(logic [7:0] b, output bit again);
		bit dec, ok;
		int s, d;
		dec = (sm == S_DEC);
		s = rshift;
		again = 0;
		if (dec) d = (b >= "0" && b <= "9") ? b - "0" : 255;
		else begin
			if (s == 0) s = 3;
			d = hexval(b);
			if (d >= (1 << s)) d = 255;
		end
		if (b == "'" && !fsep) begin
			grow(ok);
			if (ok) fsep = 1;
			return;
		end
		if (d != 255) begin
			grow(ok);
			if (!ok) return;
			fsep = 0;
			if (dec) begin
				if (acc > 64'd1844674407370955161 || (acc == 64'd1844674407370955161 && d > 5))
					raise(E_OVERFLOW, tstart, tbytes);
				else
					acc = acc * 10 + d;
			end else begin
				if ((acc >> (64 - s)) != 0) raise(E_OVERFLOW, tstart, tbytes);
				else acc = (acc << s) | d;
			end
			return;
		end
		if (fsep) begin
			raise(E_SEP, tstart, tbytes);
			return;
		end
		if ((b | 8'h20) == "u") begin
			grow(ok);
			if (ok) begin
				funs = 1;
				sm = S_SUFFIX;
			end
			return;
		end
		if (b == "." || is_trail_b(b)) begin
			raise(E_UNSUP, tstart, tbytes);
			return;
		end
		again = 1;
		emit_num();
	endtask

	task automatic shadow_reset();
		sm = S_IDLE; ln = 1; bpos = 0; tstart = 0; tbytes = 0; acc = 0; rshift = 0;
		fsep = 0; funs = 0; latched = 0;
	endtask

	task automatic predict_request(req_s r);
		logic [31:0] p;
		bit again, ok;
		logic [7:0] b;
		outq.delete();
		b = r.b;
		if (r.kind) begin
			if (!latched) begin
				case (sm)
					S_SLASH: raise(E_BAD, tstart, 1);
					S_BOPEN, S_BLOCK, S_BSTAR: raise(E_OPEN, tstart, 2);
					S_STAR: raise(E_UNSUP, tstart, 1);
					S_NAME: emit(K_NAME, tstart, tbytes, 0, 0, E_NONE);
					S_RADIX, S_DEC: begin
						if (fsep) raise(E_SEP, tstart, tbytes);
						else emit_num();
					end
					S_ZERO, S_SUFFIX: emit_num();
					default: ;
				endcase
				if (!latched) emit(K_EOF, bpos, 0, 0, 0, E_NONE);
			end
			shadow_reset();
		end else begin
			p = bpos;
			bpos++;
			if (!latched) begin
				again = 0;
				case (sm)
					S_SLASH: begin
						if (b == "*") sm = S_BOPEN;
						else if (b == "/") sm = S_LINE;
						else raise(E_BAD, tstart, 1);
					end
					S_BOPEN, S_BLOCK, S_BSTAR: begin
						if (b == 8'h0a) begin
							ln++;
							sm = S_BLOCK;
						end else if (b == "*") sm = S_BSTAR;
						else if (b == "/" && sm == S_BSTAR) sm = S_IDLE;
						else sm = S_BLOCK;
					end
					S_LINE: if (b == 8'h0a) begin
						ln++;
						sm = S_IDLE;
					end
					S_STAR: begin
						if (b == "/") raise(E_STRAY, tstart, 2);
						else raise(E_UNSUP, tstart, 1);
					end
					S_NAME: begin
						if (is_trail_b(b)) grow(ok);
						else begin
							sm = S_IDLE;
							emit(K_NAME, tstart, tbytes, 0, 0, E_NONE);
							again = 1;
						end
					end
					S_ZERO: begin
						if (b == "." || (b | 8'h20) == "e") raise(E_UNSUP, tstart, tbytes);
						else if ((b | 8'h20) == "x" || (b | 8'h20) == "b") begin
							grow(ok);
							if (ok) begin
								rshift = ((b | 8'h20) == "x") ? 4 : 1;
								sm = S_RADIX;
							end
						end else begin
							rshift = 3;
							sm = S_RADIX;
							digit_scan(b, again);
						end
					end
					S_RADIX, S_DEC: digit_scan(b, again);
					S_SUFFIX: begin
						if (b == "." || is_trail_b(b)) raise(E_UNSUP, tstart, tbytes);
						else begin
							emit_num();
							again = 1;
						end
					end
					default: again = 1;
				endcase
				if (again) idle_scan(b, p);
			end
		end
		if (outq.size() > 0) outq[outq.size() - 1].last = 1;
		foreach (outq[i]) expected_tokens.push_back(outq[i]);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic add_str(string s);
		req_s r;
		for (int i = 0; i < s.len(); i++) begin
			r.kind = 0;
			r.b = s[i];
			pending_reqs.push_back(r);
		end
	endtask

	task automatic add_end();
		req_s r;
		r.kind = 1;
		r.b = $urandom;
		pending_reqs.push_back(r);
	endtask

	task automatic add_byte(logic [7:0] b);
		req_s r;
		r.kind = 0;
		r.b = b;
		pending_reqs.push_back(r);
	endtask

	function automatic string rand_frag();
		string pieces[30];
		string s;
		pieces = '{"0x", "0b", "0", "1'2", "18446744073709551615", "18446744073709551616",
			"0xFFFFFFFFFFFFFFFF", "2147483648", "4294967295u", "9223372036854775808",
			"abc_", "x9", " ", "\n", "\t", "\r", "-", "{", "}", ",", "=", "/*c*/",
			"//l\n", "0777", "0b101'1", "0x'f", "3U", "12.", "7e", "*/"};
		s = pieces[$urandom_range(0, 29)];
		return s;
	endfunction

	initial begin
		string t;
		add_str("-{},= x_1\n\t\r 0 0x1F 0b101 017 1'000u 0X 0B\n");
		add_end();
		add_str("18446744073709551615 0xFFFFFFFFFFFFFFFFu 9223372036854775808");
		add_end();
		add_str("18446744073709551616");
		add_end();
		add_str("/*/ */ /* a\n"); add_end();
		add_str("/ x"); add_end();
		add_str("*/"); add_end();
		add_str("* "); add_end();
		add_str("1''2"); add_end();
		add_str("0.5"); add_end();
		add_byte(8'h00); add_end();
		add_byte(8'hFF); add_end();
		add_str("5ux"); add_end();
		add_str("1'"); add_end();
		add_str("/"); add_end();
		add_str("*"); add_end();
		add_str("0x"); add_end();
		add_end();
		while (pending_reqs.size() < 700) begin
			if ($urandom_range(0, 9) < 8) begin
				t = rand_frag();
				add_str(t);
				if ($urandom_range(0, 2) == 0) add_byte(" ");
			end else begin
				add_byte($urandom);
			end
			if ($urandom_range(0, 14) == 0) add_end();
		end
		add_end();
		stim_done = 1;
	end

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	initial shadow_reset();

	int drv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 0;
			kind <= 0;
			source_byte <= 0;
		end else begin
			if (push && !full) begin
				predict_request('{kind: kind, b: source_byte});
				void'(pending_reqs.pop_front());
			end
			if (push && full) begin
			end else if (drv_gap > 0) begin
				drv_gap--;
				push <= 0;
			end else if (pending_reqs.size() > (push && !full ? 1 : 0) || (!push
					&& pending_reqs.size() > 0)) begin
				req_s nx;
				nx = (push && !full) ? pending_reqs[0] : pending_reqs[0];
				kind <= nx.kind;
				source_byte <= nx.b;
				push <= 1;
				drv_gap = gap_len();
			end else begin
				push <= 0;
			end
		end
	end

	int mon_gap = 0;
	int hold_cnt = 0;
	bit hold_done = 0;
	int mon_cycles = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 0;
		end else begin
			mon_cycles++;
			if (pop && !empty) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t unexpected token kind %0d", $time, token_kind);
					errors++;
				end else begin
					token_t e;
					e = expected_tokens.pop_front();
					if (e !== {token_kind, token_line, token_offset, token_length,
							literal_value, literal_type, error_code, last_of_run}) begin
						$display("%0t mismatch exp k%0d l%0d o%0d n%0d v%h t%0d e%0d z%0d",
							$time, e.kind, e.line, e.offset, e.length, e.value, e.ltype,
							e.err, e.last);
						$display("%0t          act k%0d l%0d o%0d n%0d v%h t%0d e%0d z%0d",
							$time, token_kind, token_line, token_offset, token_length,
							literal_value, literal_type, error_code, last_of_run);
						errors++;
					end
				end
			end
			if (!hold_done && mon_cycles == 200) hold_cnt = 60;
			if (hold_cnt > 0) begin
				hold_cnt--;
				if (hold_cnt == 0) hold_done = 1;
				pop <= 0;
			end else if (mon_gap > 0) begin
				mon_gap--;
				pop <= 0;
			end else begin
				pop <= 1;
				mon_gap = gap_len();
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 2000) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_reqs.size() == 0 && !push);
		wait (expected_tokens.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_tokens.size() == 0 && empty) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+src
src/cts_pkg.sv
src/cts_front.sv
src/cts_back.sv
src/c_token_scanner.sv
sim/tb_top.sv
